// ----- rtl/nbgu_pkg.sv -----
package nbgu_pkg;

    localparam int CoordW   = 48;
    localparam int FracW    = 24;
    localparam int IdW      = 16;
    localparam int MassW    = 32;
    localparam int CfgW     = 32;
    localparam int NormBits = 16;
    localparam int DataInW  = IdW + 6 * CoordW + MassW;
    localparam int DataOutW = 6 * CoordW;
    // exponent of the pull before the normalizing shift is applied
    localparam int ExBase   = 3 * FracW - 32;

    typedef enum logic {
        K_LOAD    = 1'b0,
        K_CONTRIB = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_GRAVITY = 1'b0,
        CFG_STEP    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind                   kind;
        logic                    last;
        logic [IdW-1:0]          id;
        logic [2:0][CoordW-1:0]  pos;
        logic [2:0][CoordW-1:0]  vel;
        logic [MassW-1:0]        mass;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_NORM, S_SQ, S_DEN, S_NUM, S_PE, S_DIVSET,
        S_DIV, S_ACC, S_DT2, S_TV, S_TA2, S_TA, S_UPDAX, S_EMIT
    } t_state;

    function automatic logic signed [63:0] f_sat_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            f_sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            f_sat_add = s[63:0];
        end
    endfunction

    function automatic logic [63:0] f_abs(input logic signed [63:0] v);
        f_abs = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // sign * trunc(product / 2^sh), magnitude capped at 2^63, then saturated
    function automatic logic signed [63:0] f_term(input logic [127:0] p, input int sh,
                                                  input logic neg);
        logic [127:0] m;
        logic [63:0]  mag;
        m = p >> sh;
        if (m[127:64] != 64'd0 || m[63:0] > {1'b1, 63'd0}) begin
            mag = {1'b1, 63'd0};
        end else begin
            mag = m[63:0];
        end
        if (neg) begin
            f_term = mag[63] ? {1'b1, 63'd0} : -$signed(mag);
        end else begin
            f_term = mag[63] ? {1'b0, {63{1'b1}}} : $signed(mag);
        end
    endfunction

    function automatic logic [CoordW-1:0] f_clamp(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
        lo = -hi - 64'sd1;
        if (v > hi) begin
            f_clamp = hi[CoordW-1:0];
        end else if (v < lo) begin
            f_clamp = lo[CoordW-1:0];
        end else begin
            f_clamp = v[CoordW-1:0];
        end
    endfunction

endpackage

// ----- rtl/nbgu_front.sv -----
module nbgu_front
    import nbgu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [DataInW-1:0] i_s_axis_tdata,
    input  logic               i_s_axis_tuser,
    input  logic               i_s_axis_tlast,
    output logic               o_item_valid,
    input  logic               i_item_ready,
    output t_item              o_item
);

    t_item      r_queue [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.kind = i_s_axis_tuser ? K_CONTRIB : K_LOAD;
        w_item.last = i_s_axis_tlast;
        w_item.id   = i_s_axis_tdata[IdW-1:0];
        for (int i = 0; i < 3; i++) begin
            w_item.pos[i] = i_s_axis_tdata[IdW + i*CoordW +: CoordW];
            w_item.vel[i] = i_s_axis_tdata[IdW + (3+i)*CoordW +: CoordW];
        end
        w_item.mass = i_s_axis_tdata[IdW + 6*CoordW +: MassW];
    end

    assign o_s_axis_tready = (r_count != 2'd2);
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item_valid    = (r_count != 2'd0);
    assign w_pop           = o_item_valid && i_item_ready;
    assign o_item          = r_queue[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- rtl/nbgu_mul.sv -----
module nbgu_mul
    import nbgu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sel;
    logic [127:0] r_acc;
    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [1:0]   w_weight;

    assign w_ah     = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh     = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_weight = 2'(r_pp_sel[1]) + 2'(r_pp_sel[0]);
    assign o_done   = r_done;
    assign o_prod   = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp     <= w_ah * w_bh;
                r_pp_sel <= r_cnt[1:0];
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + ({64'd0, r_pp} << {w_weight, 5'd0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/nbgu_engine.sv -----
module nbgu_engine
    import nbgu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CfgW-1:0]     i_gravity,
    input  logic [CfgW-1:0]     i_step,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  t_item               i_item,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DataOutW-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tuser
);

    t_state                    r_state;
    t_state                    n_state;
    t_item                     r_item;
    logic signed [CoordW-1:0]  r_cur_pos [3];
    logic signed [CoordW-1:0]  r_cur_vel [3];
    logic [IdW-1:0]            r_cur_id;
    logic signed [63:0]        r_acc [3];
    logic                      r_flag;
    logic [CoordW:0]           r_mag [3];
    logic [2:0]                r_neg;
    logic signed [6:0]         r_shift;
    logic [1:0]                r_ax;
    logic [6:0]                r_cnt;
    logic [33:0]               r_q;
    logic [33:0]               r_sq_rem;
    logic [33:0]               r_root;
    logic [51:0]               r_den;
    logic [63:0]               r_num;
    logic [79:0]               r_p [3];
    logic [63:0]               r_xl [3];
    logic [51:0]               r_rem [3];
    logic [63:0]               r_quo [3];
    logic [2:0]                r_dsat;
    logic [63:0]               r_dt2;
    logic signed [63:0]        r_t1;
    logic signed [63:0]        r_t2;
    logic signed [63:0]        r_t3;
    logic                      r_issued;
    logic [CoordW-1:0]         r_out_pos [3];
    logic [CoordW-1:0]         r_out_vel [3];
    logic                      r_out_flag;
    logic                      r_out_valid;

    logic                      w_pop;
    logic                      w_mul_start;
    logic [63:0]               w_mul_a;
    logic [63:0]               w_mul_b;
    logic                      w_mul_done;
    logic [127:0]              w_prod;
    logic [CoordW:0]           w_big;
    logic signed [7:0]         w_ex;
    logic [33:0]               w_sq_bit;
    logic                      w_emit;
    logic                      w_same_id;

    nbgu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign o_item_ready = (r_state == S_IDLE);
    assign w_pop        = i_item_valid && o_item_ready;
    assign w_same_id    = (i_item.id == r_cur_id);
    assign w_ex         = 8'(ExBase) - 8'($signed({r_shift, 1'b0}));
    assign w_sq_bit     = 34'd1 << {r_cnt[4:0], 1'b0};
    assign w_emit       = (r_state == S_EMIT) && !r_out_valid;

    always_comb begin
        w_big = r_mag[0];
        if (r_mag[1] > w_big) begin
            w_big = r_mag[1];
        end
        if (r_mag[2] > w_big) begin
            w_big = r_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = 64'd0;
        w_mul_b     = 64'd0;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    if (i_item.kind == K_CONTRIB && !w_same_id) begin
                        n_state = S_DIFF;
                    end else if (i_item.last) begin
                        n_state = S_DT2;
                    end
                end
            end
            S_DIFF: begin
                n_state = S_NORM;
            end
            S_NORM: begin
                if (w_big == '0) begin
                    n_state = r_item.last ? S_DT2 : S_IDLE;
                end else if (w_big[CoordW:NormBits] == '0 && w_big[NormBits-1]) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                w_mul_start = !r_issued;
                w_mul_a     = 64'(r_mag[r_ax]);
                w_mul_b     = 64'(r_mag[r_ax]);
                if (w_mul_done && r_ax == 2'd2) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                // square root runs first, then the product q * root
                if (r_cnt == 7'd127) begin
                    w_mul_start = !r_issued;
                end
                w_mul_a = 64'(r_q);
                w_mul_b = 64'(r_root);
                if (w_mul_done) begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                w_mul_start = !r_issued;
                w_mul_a     = 64'(i_gravity);
                w_mul_b     = 64'(r_item.mass);
                if (w_mul_done) begin
                    n_state = S_PE;
                end
            end
            S_PE: begin
                w_mul_start = !r_issued;
                w_mul_a     = r_num;
                w_mul_b     = 64'(r_mag[r_ax]);
                if (w_mul_done && r_ax == 2'd2) begin
                    n_state = S_DIVSET;
                end
            end
            S_DIVSET: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 7'd0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_item.last ? S_DT2 : S_IDLE;
            end
            S_DT2: begin
                w_mul_start = !r_issued;
                w_mul_a     = 64'(i_step);
                w_mul_b     = 64'(i_step);
                if (w_mul_done) begin
                    n_state = S_TV;
                end
            end
            S_TV: begin
                w_mul_start = !r_issued;
                w_mul_a     = f_abs(64'(r_cur_vel[r_ax]));
                w_mul_b     = 64'(i_step);
                if (w_mul_done) begin
                    n_state = S_TA2;
                end
            end
            S_TA2: begin
                w_mul_start = !r_issued;
                w_mul_a     = f_abs(r_acc[r_ax]);
                w_mul_b     = r_dt2;
                if (w_mul_done) begin
                    n_state = S_TA;
                end
            end
            S_TA: begin
                w_mul_start = !r_issued;
                w_mul_a     = f_abs(r_acc[r_ax]);
                w_mul_b     = 64'(i_step);
                if (w_mul_done) begin
                    n_state = S_UPDAX;
                end
            end
            S_UPDAX: begin
                n_state = (r_ax == 2'd2) ? S_EMIT : S_TV;
            end
            S_EMIT: begin
                if (!r_out_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and model state
    always_ff @(posedge i_clk) begin
        logic [149:0]       x;
        logic [51:0]        rem2;
        logic [63:0]        v;
        logic signed [63:0] sv;
        logic [33:0]        trial;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_cur_pos[i] <= '0;
                r_cur_vel[i] <= '0;
                r_acc[i]     <= '0;
            end
            r_cur_id    <= '0;
            r_flag      <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ax        <= 2'd0;
            r_cnt       <= 7'd0;
        end else begin
            if (w_mul_start) begin
                r_issued <= 1'b1;
            end
            if (w_mul_done) begin
                r_issued <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_item <= i_item;
                        r_ax   <= 2'd0;
                        if (i_item.kind == K_LOAD) begin
                            r_cur_id <= i_item.id;
                            for (int i = 0; i < 3; i++) begin
                                r_cur_pos[i] <= i_item.pos[i];
                                r_cur_vel[i] <= i_item.vel[i];
                                r_acc[i]     <= '0;
                            end
                            r_flag <= 1'b0;
                        end
                    end
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        sv = 64'($signed(r_item.pos[i])) - 64'(r_cur_pos[i]);
                        r_neg[i] <= sv[63];
                        r_mag[i] <= sv[63] ? (CoordW+1)'(-sv) : sv[CoordW:0];
                    end
                    r_shift <= 7'sd0;
                    r_q     <= 34'd0;
                end
                S_NORM: begin
                    if (w_big == '0) begin
                        r_flag <= 1'b1;
                    end else if (w_big[CoordW:NormBits] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                        r_shift <= r_shift + 7'sd1;
                    end else if (!w_big[NormBits-1]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                        r_shift <= r_shift - 7'sd1;
                    end
                end
                S_SQ: begin
                    if (w_mul_done) begin
                        r_q <= r_q + w_prod[33:0];
                        if (r_ax == 2'd2) begin
                            r_ax     <= 2'd0;
                            r_cnt    <= 7'd16;
                            r_root   <= 34'd0;
                            r_sq_rem <= r_q + w_prod[33:0];
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end
                S_DEN: begin
                    // one root bit per cycle, then the count parks at all ones
                    if (r_cnt != 7'd127) begin
                        trial = r_root + w_sq_bit;
                        if (r_sq_rem >= trial) begin
                            r_sq_rem <= r_sq_rem - trial;
                            r_root   <= (r_root >> 1) + w_sq_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_cnt <= (r_cnt == 7'd0) ? 7'd127 : r_cnt - 7'd1;
                    end
                    if (w_mul_done) begin
                        r_den <= w_prod[51:0];
                    end
                end
                S_NUM: begin
                    if (w_mul_done) begin
                        r_num <= w_prod[63:0];
                    end
                end
                S_PE: begin
                    if (w_mul_done) begin
                        r_p[r_ax] <= w_prod[79:0];
                        r_ax      <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    end
                end
                S_DIVSET: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_ex[7]) begin
                            x = {70'd0, r_p[i]} >> 7'(-w_ex);
                        end else begin
                            x = {70'd0, r_p[i]} << w_ex[6:0];
                        end
                        r_dsat[i] <= (x[149:64] >= 86'(r_den));
                        r_rem[i]  <= x[115:64];
                        r_xl[i]   <= x[63:0];
                        r_quo[i]  <= 64'd0;
                    end
                    r_cnt <= 7'd63;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        rem2 = {r_rem[i][50:0], r_xl[i][63]};
                        if (rem2 >= r_den) begin
                            r_rem[i] <= rem2 - r_den;
                            r_quo[i] <= {r_quo[i][62:0], 1'b1};
                        end else begin
                            r_rem[i] <= rem2;
                            r_quo[i] <= {r_quo[i][62:0], 1'b0};
                        end
                        r_xl[i] <= r_xl[i] << 1;
                    end
                    if (r_cnt != 7'd0) begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_ACC: begin
                    for (int i = 0; i < 3; i++) begin
                        v  = (r_dsat[i] || r_quo[i][63]) ? {1'b0, {63{1'b1}}} : r_quo[i];
                        sv = r_neg[i] ? -$signed(v) : $signed(v);
                        r_acc[i] <= f_sat_add(r_acc[i], sv);
                    end
                end
                S_DT2: begin
                    r_ax <= 2'd0;
                    if (w_mul_done) begin
                        r_dt2 <= w_prod[63:0];
                    end
                end
                S_TV: begin
                    if (w_mul_done) begin
                        r_t1 <= f_term(w_prod, 16, r_cur_vel[r_ax][CoordW-1]);
                    end
                end
                S_TA2: begin
                    if (w_mul_done) begin
                        r_t2 <= f_term(w_prod, 33, r_acc[r_ax][63]);
                    end
                end
                S_TA: begin
                    if (w_mul_done) begin
                        r_t3 <= f_term(w_prod, 16, r_acc[r_ax][63]);
                    end
                end
                S_UPDAX: begin
                    r_cur_pos[r_ax] <= f_clamp(f_sat_add(f_sat_add(64'(r_cur_pos[r_ax]), r_t1),
                                                         r_t2));
                    r_cur_vel[r_ax] <= f_clamp(f_sat_add(64'(r_cur_vel[r_ax]), r_t3));
                    r_acc[r_ax]     <= '0;
                    r_ax            <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        for (int i = 0; i < 3; i++) begin
                            r_out_pos[i] <= r_cur_pos[i];
                            r_out_vel[i] <= r_cur_vel[i];
                        end
                        r_out_flag <= r_flag;
                        r_flag     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_flag;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_m_axis_tdata[i*CoordW +: CoordW]     = r_out_pos[i];
            o_m_axis_tdata[(3+i)*CoordW +: CoordW] = r_out_vel[i];
        end
    end

`ifndef SYNTH
    a_norm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (w_big[CoordW:NormBits] == '0 && w_big[NormBits-1]))
        else $error("normalized distance outside its window");

    // root of a sum of squares in [2^30, 3*2^32) lies in [2^15, 2^17)
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NUM) |-> (r_root[33:NormBits+1] == '0 &&
                                r_root[NormBits:NormBits-1] != 2'b00))
        else $error("root of the squared distance out of range");

    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den[51:45] != '0))
        else $error("divisor below its lower bound");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not held after emit");
`endif

endmodule

// ----- rtl/nbody_gravity_body_update_top.sv -----
// Direct-sum gravity update for one body. A load item (tuser 0) sets the current body
// and clears the acceleration sum; each contribute item (tuser 1) adds G*m*d/|d|^3 of
// another body unless it has the same id, and a pair at zero distance is skipped and
// flagged. The item with tlast high makes the block emit one transfer holding the
// new position and velocity, with the zero-distance flag on tuser. A contribute item
// runs normalizing shifts, 17 square-root steps, 64 steps of the three-lane restoring
// divider and eight products on the one shared 64x64 multiplier, each built from four
// 32x32 partial products. An update runs ten products on the same multiplier. A
// two-entry queue buffers input transfers and the result sits in an output register,
// so both sides stall independently. Configuration writes are taken in any cycle and
// must arrive while the block is idle.
module nbody_gravity_body_update_top
    import nbgu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // body_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass
    input  logic [DataInW-1:0]  i_s_axis_tdata,
    // op
    input  logic                i_s_axis_tuser,
    input  logic                i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [DataOutW-1:0] o_m_axis_tdata,
    // coincident_seen
    output logic                o_m_axis_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CfgW-1:0]     i_cfg_data
);

    logic [CfgW-1:0] r_gravity;
    logic [CfgW-1:0] r_step;
    logic            w_item_valid;
    logic            w_item_ready;
    t_item           w_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= CfgW'(1);
            r_step    <= CfgW'(65536);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRAVITY: r_gravity <= i_cfg_data;
                CFG_STEP:    r_step    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    nbgu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_item_valid    (w_item_valid),
        .i_item_ready    (w_item_ready),
        .o_item          (w_item)
    );

    nbgu_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_gravity       (r_gravity),
        .i_step          (r_step),
        .i_item_valid    (w_item_valid),
        .o_item_ready    (w_item_ready),
        .i_item          (w_item),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
